>>> design/dgs_pkg.sv
package dgs_pkg;

	// Request codes.
	localparam logic [2:0] REQ_CLEAR       = 3'd0;
	localparam logic [2:0] REQ_ADD_NODE    = 3'd1;
	localparam logic [2:0] REQ_ADD_ARC     = 3'd2;
	localparam logic [2:0] REQ_DEL_NODE    = 3'd3;
	localparam logic [2:0] REQ_DEL_ARC     = 3'd4;
	localparam logic [2:0] REQ_SEARCH_NODE = 3'd5;
	localparam logic [2:0] REQ_SEARCH_ARC  = 3'd6;

	// Status codes.
	localparam logic [2:0] ST_DONE         = 3'd0;
	localparam logic [2:0] ST_FOUND        = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND    = 3'd2;
	localparam logic [2:0] ST_NODE_EXISTS  = 3'd3;
	localparam logic [2:0] ST_ARC_EXISTS   = 3'd4;
	localparam logic [2:0] ST_OVERFLOW     = 3'd5;
	localparam logic [2:0] ST_NODE_MISSING = 3'd6;
	localparam logic [2:0] ST_ARC_MISSING  = 3'd7;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic look;
		logic exec;
	} ctl_t;

endpackage

>>> design/dgs_ctrl.sv
module dgs_ctrl import dgs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output logic done,
	output ctl_t ctl
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOOK = 2'd1;
	localparam logic [1:0] S_EXEC = 2'd2;

	logic [1:0] state_q;
	logic       done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_EXEC);
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_LOOK;
				end
				S_LOOK: state_q <= S_EXEC;
				S_EXEC: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		ctl.load = start && (state_q == S_IDLE);
		ctl.look = (state_q == S_LOOK);
		ctl.exec = (state_q == S_EXEC);
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

>>> design/dgs_datapath.sv
module dgs_datapath import dgs_pkg::*; #(
	parameter int MAX_NODES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ctl_t       ctl,
	input  logic [2:0] req_type,
	input  logic [7:0] first_key,
	input  logic [7:0] second_key,
	output logic [2:0] status
);

	localparam int SW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

	function automatic logic [SW-1:0] enc(input logic [MAX_NODES-1:0] v);
		logic [SW-1:0] idx;
		idx = '0;
		for (int i = 0; i < MAX_NODES; i++) begin
			if (v[i]) idx = idx | SW'(i);
		end
		return idx;
	endfunction

	// Request latched at accept.
	logic [2:0] req_q;
	logic [7:0] key_a_q;
	logic [7:0] key_b_q;

	// Graph state.
	logic [7:0]           node_key_q [MAX_NODES];
	logic [MAX_NODES-1:0] used_q;
	logic [MAX_NODES-1:0] arc_q [MAX_NODES];

	// Lookup results.
	logic          found_a_q, found_b_q, one_free_q, two_free_q, same_q;
	logic [SW-1:0] sa_q, sb_q, f1_q, f2_q;
	logic [2:0]    status_q;

	logic [MAX_NODES-1:0] match_a, match_b, free_v, f1_oh, rest_v;

	always_comb begin
		for (int i = 0; i < MAX_NODES; i++) begin
			match_a[i] = used_q[i] && (node_key_q[i] == key_a_q);
			match_b[i] = used_q[i] && (node_key_q[i] == key_b_q);
		end
		free_v = ~used_q;
		f1_oh  = free_v & (~free_v + MAX_NODES'(1));
		rest_v = free_v & ~f1_oh;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			req_q   <= req_type;
			key_a_q <= first_key;
			key_b_q <= second_key;
		end
		if (ctl.look) begin
			found_a_q  <= |match_a;
			found_b_q  <= |match_b;
			sa_q       <= enc(match_a);
			sb_q       <= enc(match_b);
			f1_q       <= enc(f1_oh);
			f2_q       <= enc(rest_v & (~rest_v + MAX_NODES'(1)));
			one_free_q <= |free_v;
			two_free_q <= |rest_v;
			same_q     <= (key_a_q == key_b_q);
		end
	end

	// Execute step.
	logic                 arc_bit, pa, pb, ovf, wr_a, wr_b;
	logic [SW-1:0]        slot_a, slot_b;
	logic [2:0]           st_d;
	logic [MAX_NODES-1:0] used_d;
	logic [MAX_NODES-1:0] arc_d [MAX_NODES];

	always_comb begin
		arc_bit = found_a_q && found_b_q && arc_q[sa_q][sb_q];
		pa      = !found_a_q;
		pb      = !found_b_q && !(pa && same_q);
		ovf     = (pa && pb && !two_free_q) || ((pa || pb) && !one_free_q);
		slot_a  = found_a_q ? sa_q : f1_q;
		if (found_b_q)          slot_b = sb_q;
		else if (pa && same_q)  slot_b = f1_q;
		else if (pa)            slot_b = f2_q;
		else                    slot_b = f1_q;
		st_d   = ST_DONE;
		used_d = used_q;
		wr_a   = 1'b0;
		wr_b   = 1'b0;
		for (int r = 0; r < MAX_NODES; r++) arc_d[r] = arc_q[r];
		case (req_q)
			REQ_CLEAR: begin
				used_d = '0;
				for (int r = 0; r < MAX_NODES; r++) arc_d[r] = '0;
			end
			REQ_ADD_NODE: begin
				if (found_a_q) st_d = ST_NODE_EXISTS;
				else if (!one_free_q) st_d = ST_OVERFLOW;
				else begin
					wr_a = 1'b1;
					used_d[f1_q] = 1'b1;
					arc_d[f1_q] = '0;
				end
			end
			REQ_ADD_ARC: begin
				if (arc_bit) st_d = ST_ARC_EXISTS;
				else if (ovf) st_d = ST_OVERFLOW;
				else begin
					wr_a = pa;
					wr_b = pb;
					if (pa) begin
						used_d[f1_q] = 1'b1;
						arc_d[f1_q] = '0;
					end
					if (pb) begin
						used_d[slot_b] = 1'b1;
						arc_d[slot_b] = '0;
					end
					arc_d[slot_a][slot_b] = 1'b1;
				end
			end
			REQ_DEL_NODE: begin
				if (!found_a_q) st_d = ST_NODE_MISSING;
				else begin
					used_d[sa_q] = 1'b0;
					for (int r = 0; r < MAX_NODES; r++) arc_d[r][sa_q] = 1'b0;
					arc_d[sa_q] = '0;
				end
			end
			REQ_DEL_ARC: begin
				if (!arc_bit) st_d = ST_ARC_MISSING;
				else arc_d[sa_q][sb_q] = 1'b0;
			end
			REQ_SEARCH_NODE: st_d = found_a_q ? ST_FOUND : ST_NOT_FOUND;
			REQ_SEARCH_ARC:  st_d = arc_bit ? ST_FOUND : ST_NOT_FOUND;
			default: st_d = ST_DONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			for (int r = 0; r < MAX_NODES; r++) arc_q[r] <= '0;
		end else if (ctl.exec) begin
			used_q <= used_d;
			for (int r = 0; r < MAX_NODES; r++) arc_q[r] <= arc_d[r];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			status_q <= st_d;
			if (wr_a) node_key_q[f1_q] <= key_a_q;
			if (wr_b) node_key_q[slot_b] <= key_b_q;
		end
	end

	assign status = status_q;

endmodule

>>> design/directed_graph_store.sv
// Directed graph store. Each request beat (start high while busy is low) carries an
// operation and one or two byte keys, and returns exactly one status beat, marked by
// done for a single cycle; the receiver cannot stall, so status must be captured on
// the cycle done is high. Between accept and the status beat a request is latched, then
// the parallel key compare and free-slot search runs over all MAX_NODES slots, then the
// change is applied; the status register then shows the result while the next request
// can already be accepted. No clearing pass is needed after reset.
module directed_graph_store import dgs_pkg::*; #(
	parameter int MAX_NODES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] req_type,
	input  logic [7:0] first_key,
	input  logic [7:0] second_key,
	output logic       done,
	output logic [2:0] status
);

	ctl_t ctl;

	// The controller sequences latch, lookup and execute for one request at a time.
	dgs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl)
	);

	// The datapath holds the node keys, slot occupancy and the adjacency matrix.
	dgs_datapath #(.MAX_NODES(MAX_NODES)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.req_type   (req_type),
		.first_key  (first_key),
		.second_key (second_key),
		.status     (status)
	);

	// Only one step of the sequence is commanded in any cycle.
	a_ctl_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.load, ctl.look, ctl.exec}))
		else $error("more than one datapath command at once");

	// An accepted request makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	// A status beat follows the execute step and is never shown while execute is still commanded.
	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(ctl.exec) && !ctl.exec))
		else $error("status beat without execute step");

endmodule
